// File: rtl/world_to_screen_projection_assert.svh
// Assertion helpers for the projection pipeline.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// Same-cycle implication, off during reset.
`define WTSP_ASSERT_IMPLY(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, off during reset.
`define WTSP_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// File: rtl/wtsp_pkg.sv
package wtsp_pkg;

   localparam int CLIP_W    = 58;
   localparam int REM_W     = 59;
   localparam int FRAC_BITS = 20;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int DIV_STEPS = QUO_W;
   localparam logic signed [CLIP_W-1:0] W_MIN_Q16 = 58'sd66;

   typedef enum logic [2:0] {
      REG_X_XY,
      REG_X_ZT,
      REG_Y_XY,
      REG_Y_ZT,
      REG_W_XY,
      REG_W_ZT,
      REG_WIDTH,
      REG_HEIGHT
   } reg_index_type;

   typedef struct packed {
      logic              live;
      logic              neg_x;
      logic              neg_y;
      logic              acc;
      logic [CLIP_W-1:0] aw;
      logic [REM_W-1:0]  rem_x;
      logic [REM_W-1:0]  rem_y;
      logic [QUO_W-1:0]  f_x;
      logic [QUO_W-1:0]  f_y;
   } div_type;

   // one restoring step on both quotients
   function automatic div_type div_step(div_type d);
      div_type          r;
      logic [REM_W-1:0] sx;
      logic [REM_W-1:0] sy;
      logic [REM_W-1:0] awx;
      r   = d;
      awx = REM_W'(d.aw);
      sx  = {d.rem_x[REM_W-2:0], 1'b0};
      sy  = {d.rem_y[REM_W-2:0], 1'b0};
      r.f_x = {d.f_x[QUO_W-2:0], 1'b0};
      r.f_y = {d.f_y[QUO_W-2:0], 1'b0};
      if (sx >= awx) begin
         r.rem_x  = sx - awx;
         r.f_x[0] = 1'b1;
      end else begin
         r.rem_x = sx;
      end
      if (sy >= awx) begin
         r.rem_y  = sy - awx;
         r.f_y[0] = 1'b1;
      end else begin
         r.rem_y = sy;
      end
      return r;
   endfunction

endpackage

// File: rtl/wtsp_req_if.sv
interface wtsp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;
   logic               ignore_depth;

   modport source (output valid, world_x, world_y, world_z, ignore_depth, input ready);
   modport sink   (input valid, world_x, world_y, world_z, ignore_depth, output ready);
endinterface

// File: rtl/wtsp_rsp_if.sv
interface wtsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        position_written;
   logic        accepted;
   logic [15:0] screen_x;
   logic [15:0] screen_y;

   modport source (output valid, position_written, accepted, screen_x, screen_y, input ready);
   modport sink   (input valid, position_written, accepted, screen_x, screen_y, output ready);
endinterface

// File: rtl/world_to_screen_projection.sv
// Channel   Dir  Word
// req_ch    in   world_x, world_y, world_z (Q24.8), ignore_depth
// rsp_ch    out  position_written, accepted, screen_x, screen_y (Q12.4)
// psel etc  in   64-bit APB register writes at byte address 8*index
//
// One word per cycle sustained while the output is not stalled. The pipeline is the
// 21-stage restoring divider (one quotient bit per stage) plus multiply, sum, scale
// and output stages. Reset clears stage valid bits and weights, and sets the window
// to 1920x1080. A stalled output holds only as far back as needed: bubbles collapse,
// so upstream stages keep taking words while the result waits.
module world_to_screen_projection
   import wtsp_pkg::*;
#(
   parameter int SCREEN_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   wtsp_req_if.sink          req_ch,
   wtsp_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [5:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

`include "world_to_screen_projection_assert.svh"

   localparam int SB    = SCREEN_BITS;
   localparam int NST   = DIV_STEPS + 4;    // prod, sum, divider, scale, output
   localparam int S_DIV = 2;
   localparam int S_MUL = S_DIV + DIV_STEPS;
   localparam int S_OUT = S_MUL + 1;

   // ---------------- configuration registers ----------------
   logic [63:0] weight_ff [6];
   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) weight_ff[i] <= '0;
         width_ff  <= 12'd1920;
         height_ff <= 12'd1080;
      end else if (wr) begin
         case (paddr[5:3])
            REG_X_XY:   weight_ff[0] <= pwdata;
            REG_X_ZT:   weight_ff[1] <= pwdata;
            REG_Y_XY:   weight_ff[2] <= pwdata;
            REG_Y_ZT:   weight_ff[3] <= pwdata;
            REG_W_XY:   weight_ff[4] <= pwdata;
            REG_W_ZT:   weight_ff[5] <= pwdata;
            REG_WIDTH:  width_ff  <= pwdata[11:0];
            REG_HEIGHT: height_ff <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[5:3])
         REG_X_XY:   prdata = weight_ff[0];
         REG_X_ZT:   prdata = weight_ff[1];
         REG_Y_XY:   prdata = weight_ff[2];
         REG_Y_ZT:   prdata = weight_ff[3];
         REG_W_XY:   prdata = weight_ff[4];
         REG_W_ZT:   prdata = weight_ff[5];
         REG_WIDTH:  prdata = {52'd0, width_ff};
         REG_HEIGHT: prdata = {52'd0, height_ff};
         default:    prdata = '0;
      endcase
   end

   // keep only the low SCREEN_BITS of the window size
   logic [SB+11:0] wd_ext;
   logic [SB+11:0] ht_ext;
   logic [SB-1:0]  wd;
   logic [SB-1:0]  ht;
   logic [SB+2:0]  hx;
   logic [SB+2:0]  hy;
   assign wd_ext = {{SB{1'b0}}, width_ff};
   assign ht_ext = {{SB{1'b0}}, height_ff};
   assign wd     = wd_ext[SB-1:0];
   assign ht     = ht_ext[SB-1:0];
   assign hx     = {wd, 3'b000};
   assign hy     = {ht, 3'b000};

   // ---------------- flow control ----------------
   // advance a stage when it is empty or its successor advances
   logic v_ff [NST];
   logic en   [NST];

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_ch.ready;
      for (int i = NST - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) v_ff[i] <= 1'b0;
      end else begin
         if (en[0]) v_ff[0] <= req_ch.valid;
         for (int i = 1; i < NST; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // ---------------- stage 0: nine products ----------------
   logic signed [63:0] prod_ff [9];
   logic               ign0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[3*r]   <= $signed(weight_ff[2*r][63:32]) * req_ch.world_x;
            prod_ff[3*r+1] <= $signed(weight_ff[2*r][31:0]) * req_ch.world_y;
            prod_ff[3*r+2] <= $signed(weight_ff[2*r+1][63:32]) * req_ch.world_z;
         end
         ign0_ff <= req_ch.ignore_depth;
      end
   end

   // ---------------- stage 1: floor to Q.16 and sum rows ----------------
   logic signed [CLIP_W-1:0] clip_ff [3];
   logic                     ign1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int r = 0; r < 3; r++) begin
            clip_ff[r] <= CLIP_W'($signed(prod_ff[3*r][63:8]))
                        + CLIP_W'($signed(prod_ff[3*r+1][63:8]))
                        + CLIP_W'($signed(prod_ff[3*r+2][63:8]))
                        + CLIP_W'($signed(weight_ff[2*r+1][31:0]));
         end
         ign1_ff <= ign0_ff;
      end
   end

   // ---------------- stage 2: magnitudes, range checks, integer bit ------
   logic [CLIP_W-1:0] acx;
   logic [CLIP_W-1:0] acy;
   logic [CLIP_W-1:0] aw;
   div_type           d_in;
   div_type           d_ff [DIV_STEPS];

   always_comb begin
      acx = clip_ff[0][CLIP_W-1] ? CLIP_W'(-clip_ff[0]) : clip_ff[0];
      acy = clip_ff[1][CLIP_W-1] ? CLIP_W'(-clip_ff[1]) : clip_ff[1];
      aw  = clip_ff[2][CLIP_W-1] ? CLIP_W'(-clip_ff[2]) : clip_ff[2];
      d_in.live  = (clip_ff[2] != '0) && (acx <= aw) && (acy <= aw);
      d_in.neg_x = clip_ff[0][CLIP_W-1] != clip_ff[2][CLIP_W-1];
      d_in.neg_y = clip_ff[1][CLIP_W-1] != clip_ff[2][CLIP_W-1];
      d_in.acc   = (clip_ff[2] >= W_MIN_Q16) || ign1_ff;
      d_in.aw    = aw;
      // ratio is at most one, so the integer bit is set only on equality
      d_in.f_x   = QUO_W'(acx == aw);
      d_in.f_y   = QUO_W'(acy == aw);
      d_in.rem_x = (acx == aw) ? '0 : REM_W'(acx);
      d_in.rem_y = (acy == aw) ? '0 : REM_W'(acy);
   end

   always_ff @(posedge clock) begin
      if (en[S_DIV]) d_ff[0] <= d_in;
   end

   // ---------------- divider: one fraction bit per stage ----------------
   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en[S_DIV+k]) d_ff[k] <= div_step(d_ff[k-1]);
      end
   end

   // ---------------- scale: half window times ratio ----------------
   logic [SB+QUO_W+2:0] px;
   logic [SB+QUO_W+2:0] py;
   logic [SB+2:0]       offx_ff;
   logic [SB+2:0]       offy_ff;
   logic                live_ff;
   logic                nx_ff;
   logic                ny_ff;
   logic                acc_ff;

   assign px = hx * d_ff[DIV_STEPS-1].f_x;
   assign py = hy * d_ff[DIV_STEPS-1].f_y;

   always_ff @(posedge clock) begin
      if (en[S_MUL]) begin
         // ratio never exceeds one, so the offset fits the half window width
         offx_ff <= px[FRAC_BITS+SB+2:FRAC_BITS];
         offy_ff <= py[FRAC_BITS+SB+2:FRAC_BITS];
         live_ff <= d_ff[DIV_STEPS-1].live;
         nx_ff   <= d_ff[DIV_STEPS-1].neg_x;
         ny_ff   <= d_ff[DIV_STEPS-1].neg_y;
         acc_ff  <= d_ff[DIV_STEPS-1].acc;
      end
   end

   // ---------------- output: place and clip to window ----------------
   logic signed [SB+4:0] sx;
   logic signed [SB+4:0] sy;
   logic [SB+4:0]        wlim;
   logic [SB+4:0]        hlim;
   logic                 on_window;
   logic [SB+20:0]       sx_ext;
   logic [SB+20:0]       sy_ext;

   always_comb begin
      sx = nx_ff ? $signed((SB+5)'(hx)) - $signed((SB+5)'(offx_ff))
                 : $signed((SB+5)'(hx)) + $signed((SB+5)'(offx_ff));
      sy = ny_ff ? $signed((SB+5)'(hy)) + $signed((SB+5)'(offy_ff))
                 : $signed((SB+5)'(hy)) - $signed((SB+5)'(offy_ff));
      wlim   = {1'b0, wd, 4'b0000};
      hlim   = {1'b0, ht, 4'b0000};
      // far edge counts as off-window
      on_window = live_ff && !sx[SB+4] && !sy[SB+4]
                  && ($unsigned(sx) < wlim) && ($unsigned(sy) < hlim);
      sx_ext = {16'd0, $unsigned(sx)};
      sy_ext = {16'd0, $unsigned(sy)};
   end

   logic        pos_ff;
   logic        acc_out_ff;
   logic [15:0] scr_x_ff;
   logic [15:0] scr_y_ff;

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         pos_ff     <= on_window;
         acc_out_ff <= on_window && acc_ff;
         scr_x_ff   <= on_window ? sx_ext[15:0] : 16'd0;
         scr_y_ff   <= on_window ? sy_ext[15:0] : 16'd0;
      end
   end

   assign rsp_ch.valid            = v_ff[NST-1];
   assign rsp_ch.position_written = pos_ff;
   assign rsp_ch.accepted         = acc_out_ff;
   assign rsp_ch.screen_x         = scr_x_ff;
   assign rsp_ch.screen_y         = scr_y_ff;

   // ---------------- assertions ----------------
   `WTSP_ASSERT_IMPLY(a_acc_needs_pos, rsp_ch.valid && rsp_ch.accepted,
                      rsp_ch.position_written)
   `WTSP_ASSERT_IMPLY(a_zero_off_window, rsp_ch.valid && !rsp_ch.position_written,
                      (rsp_ch.screen_x == 16'd0) && (rsp_ch.screen_y == 16'd0))
   `WTSP_ASSERT_NEXT(a_width_write, wr && (paddr[5:3] == REG_WIDTH),
                     width_ff == $past(pwdata[11:0]))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import wtsp_pkg::*;
();

   localparam int SCREEN_BITS_TB = 12;
   localparam longint CYCLE_LIMIT = 3000000;

   // Expected screen word, one per accepted world point.
   typedef struct {
      bit        written;
      bit        acc;
      bit [15:0] sx;
      bit [15:0] sy;
   } screen_word_type;

   // Scoreboard: holds its own copy of the registers and predicts each word.
   class ProjectionScoreboard;
      bit [63:0]       weights [6];
      bit [11:0]       width_px;
      bit [11:0]       height_px;
      screen_word_type pending [$];
      int              errors;
      int              seen;
      int              on_screen;

      function new();
         foreach (weights[i]) weights[i] = '0;
         width_px  = 12'd1920;
         height_px = 12'd1080;
         errors    = 0;
         seen      = 0;
         on_screen = 0;
      endfunction

      function void set_reg(reg_index_type idx, bit [63:0] val);
         if (idx == REG_WIDTH) width_px = val[11:0];
         else if (idx == REG_HEIGHT) height_px = val[11:0];
         else weights[int'(idx)] = val;
      endfunction

      // Weighted sum of one clip row; products floored from Q.24 to Q.16.
      function longint clip_value(int row, longint x, longint y, longint z);
         bit [63:0] a;
         bit [63:0] b;
         longint    s;
         a = weights[row*2];
         b = weights[row*2+1];
         s = (longint'($signed(a[63:32])) * x) >>> 8;
         s += (longint'($signed(a[31:0])) * y) >>> 8;
         s += (longint'($signed(b[63:32])) * z) >>> 8;
         s += longint'($signed(b[31:0]));
         return s;
      endfunction

      // Offset from the center; drop the point when |c| > |w|.
      function bit center_offset(longint c, longint w, longint half_q4,
                                 output longint off, output bit neg);
         longint ac;
         longint aw;
         longint rem;
         longint f;
         ac  = (c < 0) ? -c : c;
         aw  = (w < 0) ? -w : w;
         off = 0;
         neg = 0;
         if (ac > aw) return 0;
         rem = ac;
         f   = 0;
         if (rem >= aw) begin
            f = 1;
            rem -= aw;
         end
         for (int i = 0; i < 20; i++) begin
            rem = rem << 1;
            f   = f << 1;
            if (rem >= aw) begin
               rem -= aw;
               f |= 1;
            end
         end
         off = (half_q4 * f) >>> 20;
         neg = (c < 0) != (w < 0);
         return 1;
      endfunction

      function void note(bit [31:0] wx, bit [31:0] wy, bit [31:0] wz, bit ign);
         screen_word_type e;
         longint px, py, pz, cx, cy, cw, hx, hy, ox, oy, sxv, syv, wd, ht;
         bit nx, ny;
         e = '{0, 0, 16'd0, 16'd0};
         wd = longint'(width_px & ((1 << SCREEN_BITS_TB) - 1));
         ht = longint'(height_px & ((1 << SCREEN_BITS_TB) - 1));
         hx = wd * 8;
         hy = ht * 8;
         px = longint'($signed(wx));
         py = longint'($signed(wy));
         pz = longint'($signed(wz));
         cx = clip_value(0, px, py, pz);
         cy = clip_value(1, px, py, pz);
         cw = clip_value(2, px, py, pz);
         if (cw != 0 && center_offset(cx, cw, hx, ox, nx)
                     && center_offset(cy, cw, hy, oy, ny)) begin
            sxv = nx ? hx - ox : hx + ox;
            syv = ny ? hy + oy : hy - oy;
            if (sxv >= 0 && syv >= 0 && sxv < wd * 16 && syv < ht * 16) begin
               e.written = 1;
               e.acc     = (cw >= 66) || ign;
               e.sx      = sxv[15:0];
               e.sy      = syv[15:0];
            end
         end
         pending.push_back(e);
      endfunction

      function void check(bit written, bit acc, bit [15:0] sx, bit [15:0] sy);
         screen_word_type e;
         seen++;
         if (pending.size() == 0) begin
            $error("result word with no point waiting");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.written) on_screen++;
         if (written !== e.written) begin
            $error("position_written expected %0d actual %0d", e.written, written);
            errors++;
         end
         if (acc !== e.acc) begin
            $error("accepted expected %0d actual %0d", e.acc, acc);
            errors++;
         end
         if (sx !== e.sx) begin
            $error("screen_x expected %0d actual %0d", e.sx, sx);
            errors++;
         end
         if (sy !== e.sy) begin
            $error("screen_y expected %0d actual %0d", e.sy, sy);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   wtsp_req_if req_ch ();
   wtsp_rsp_if rsp_ch ();

   ProjectionScoreboard board;
   longint cycles = 0;
   bit     no_idle;   // when set, both sides run without gaps
   int     phases_run;

   world_to_screen_projection #(.SCREEN_BITS(SCREEN_BITS_TB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch.sink),
      .rsp_ch  (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Observe both handshakes at the edge, before any update lands.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note(req_ch.world_x, req_ch.world_y, req_ch.world_z, req_ch.ignore_depth);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check(rsp_ch.position_written, rsp_ch.accepted,
                     rsp_ch.screen_x, rsp_ch.screen_y);
   end

   // Result side: draw a stall per word, skip it during no-idle stretches.
   initial begin : drain_words
      int gap;
      rsp_ch.ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Register write: setup cycle, then access until pready.
   task automatic write_reg(reg_index_type idx, bit [63:0] val);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= 6'(int'(idx) * 8);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, val);
   endtask

   // Drop the bus after the last write of a burst.
   task automatic release_bus();
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // Hold until every word is back, then let the pipe drain.
   task automatic settle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_weights(bit [63:0] xa, bit [63:0] xb, bit [63:0] ya,
                               bit [63:0] yb, bit [63:0] wa, bit [63:0] wb,
                               bit [11:0] wd, bit [11:0] ht);
      settle();
      write_reg(REG_X_XY, xa);
      write_reg(REG_X_ZT, xb);
      write_reg(REG_Y_XY, ya);
      write_reg(REG_Y_ZT, yb);
      write_reg(REG_W_XY, wa);
      write_reg(REG_W_ZT, wb);
      write_reg(REG_WIDTH, {52'd0, wd});
      write_reg(REG_HEIGHT, {52'd0, ht});
      release_bus();
      phases_run++;
   endtask

   // Present one world point and hold it until taken.
   task automatic send_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit ign);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1;
      req_ch.world_x      <= x;
      req_ch.world_y      <= y;
      req_ch.world_z      <= z;
      req_ch.ignore_depth <= ign;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic end_burst();
      req_ch.valid <= 0;
      @(posedge clock);
   endtask

   // Mostly points inside the view frustum of a Z-divide setup, some noise.
   task automatic send_random(int n);
      int z;
      int x;
      int y;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            send_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
         end else begin
            z = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            x = int'((longint'(z) * (int'($urandom_range(0, 2200)) - 1100)) / 1000);
            y = int'((longint'(z) * (int'($urandom_range(0, 2200)) - 1100)) / 1000);
            send_point(x, y, z, 1'($urandom_range(0, 1)));
         end
      end
      no_idle = 0;
      end_burst();
   endtask

   localparam bit [31:0] ONE_Q16 = 32'h0001_0000;

   initial begin
      bit [31:0] s;
      bit [31:0] t;
      phases_run = 0;
      no_idle = 0;
      board = new();
      reset = 1;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 0;
      req_ch.world_x = '0;
      req_ch.world_y = '0;
      req_ch.world_z = '0;
      req_ch.ignore_depth = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset weights give w of zero: every word comes back blank.
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100, 1);
      send_point(32'h0, 32'h0, 32'h0, 0);
      end_burst();

      // Plain Z divide on the default 1920x1080 window.
      load_weights({ONE_Q16, 32'd0}, 64'd0, {32'd0, ONE_Q16}, 64'd0,
                   64'd0, {ONE_Q16, 32'd0}, 12'd1920, 12'd1080);
      send_point(32'd0, 32'd0, 32'd0, 1);             // zero w
      send_point(32'd0, 32'd0, 32'd25600, 0);         // center
      send_point(32'd25600, 32'd0, 32'd25600, 0);     // right edge: off window
      send_point(-32'sd25600, 32'd0, 32'd25600, 0);   // left edge: on window
      send_point(32'd0, -32'sd25600, 32'd25600, 0);   // bottom edge: off window
      send_point(32'd0, 32'd25600, 32'd25600, 0);     // top edge
      send_point(32'd30000, 32'd0, 32'd25600, 0);     // ratio above one
      send_point(32'd10, 32'd10, 32'd16, 0);          // tiny w, depth kept
      send_point(32'd10, 32'd10, 32'd16, 1);          // tiny w, depth ignored
      send_point(32'd6, -32'sd6, 32'd17, 0);          // small w, above the depth threshold
      send_point(-32'sd1000, 32'd500, -32'sd2000, 0); // behind the camera
      send_point(-32'sd1000, 32'd500, -32'sd2000, 1);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      send_point(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 0);
      end_burst();

      // Smallest and largest windows.
      load_weights({ONE_Q16, 32'd0}, 64'd0, {32'd0, ONE_Q16}, 64'd0,
                   64'd0, {ONE_Q16, 32'd0}, 12'd1, 12'd1);
      send_point(32'd0, 32'd0, 32'd256, 0);
      send_point(32'd100, 32'd100, 32'd256, 1);
      end_burst();
      load_weights({ONE_Q16, 32'd0}, 64'd0, {32'd0, ONE_Q16}, 64'd0,
                   64'd0, {ONE_Q16, 32'd0}, 12'd4095, 12'd4095);
      send_point(-32'sd255, 32'd255, 32'd256, 0);
      send_point(32'd255, -32'sd255, 32'd256, 0);
      end_burst();
      // Zero size: nothing can land inside.
      load_weights({ONE_Q16, 32'd0}, 64'd0, {32'd0, ONE_Q16}, 64'd0,
                   64'd0, {ONE_Q16, 32'd0}, 12'd0, 12'd0);
      send_point(32'd0, 32'd0, 32'd256, 1);
      end_burst();

      // Random phases: scaled frustum setups alternate with raw weights.
      for (int p = 0; p < 8; p++) begin
         if (p % 2 == 0) begin
            s = $urandom_range(ONE_Q16 / 4, ONE_Q16 * 2);
            t = ($urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16);
            load_weights({s, 32'($urandom_range(0, 8000) - 4000)},
                         {32'd0, 32'($urandom_range(0, 2000) - 1000)},
                         {32'($urandom_range(0, 8000) - 4000), s}, 64'd0,
                         {32'd0, 32'($urandom_range(0, 200) - 100)},
                         {t, 32'($urandom_range(0, 2000) - 1000)},
                         (p == 2) ? 12'd4095 : 12'($urandom_range(1, 4095)),
                         (p == 4) ? 12'd1 : 12'($urandom_range(1, 4095)));
         end else begin
            load_weights({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         12'($urandom), 12'($urandom));
         end
         send_random(110);
      end

      settle();
      $display("Covered %0d result words (%0d on screen) over %0d register settings.",
               board.seen, board.on_screen, phases_run);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
